>>> hdl/vds_pkg.sv
// Shared types, constants and helper functions for the damped vector smoother.
// Used by every module of the block; depends on nothing else.
package vds_pkg;

	localparam int CHANNELS   = 6;
	localparam int SAMP_W     = 24;
	localparam int SUM_W      = 48;
	localparam int DAMP_W     = 16;
	localparam int MUL_W      = DAMP_W + 1;
	localparam int TICK_W     = 4;
	localparam int HALF_W     = SUM_W / 2;
	localparam int PROD_W     = HALF_W + MUL_W;
	localparam int ACC_W      = 64;
	localparam int DIV_BITS   = 4;
	localparam int DIV_CYCLES = ACC_W / DIV_BITS;
	localparam int CNT_W      = $clog2(DIV_CYCLES);

	localparam logic [TICK_W-1:0] MAX_TICKS    = 4'd15;
	localparam logic [DAMP_W-1:0] DAMP_RESET   = 16'd64881;
	localparam logic [MUL_W-1:0]  ONE_Q16      = 17'h10000;
	localparam logic [DAMP_W-1:0] HALF_LSB_Q16 = 16'h8000;

	typedef logic signed [SAMP_W-1:0] samp_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef samp_t [CHANNELS-1:0]     samp_vec_t;

	typedef struct packed {
		samp_t               look_x;
		samp_t               look_y;
		samp_t               look_z;
		samp_t               up_x;
		samp_t               up_y;
		samp_t               up_z;
		logic [DAMP_W-1:0]   damping;
		logic [TICK_W-1:0]   ticks;
		logic                restart;
	} item_t;

	typedef struct packed {
		samp_t smooth_look_x;
		samp_t smooth_look_y;
		samp_t smooth_look_z;
		samp_t smooth_up_x;
		samp_t smooth_up_y;
		samp_t smooth_up_z;
	} result_t;

	typedef enum logic [1:0] {
		OP_RESCALE,
		OP_PRESET,
		OP_TICK,
		OP_OUTPUT
	} op_t;

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_MUL_LO,
		SC_MUL_HI,
		SC_ACC,
		SC_DIV,
		SC_FIN
	} scale_state_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_PLAN,
		SQ_RESCALE,
		SQ_PRESET,
		SQ_TICK,
		SQ_OUTPUT,
		SQ_EMIT
	} seq_state_t;

	// Common command from the sequencer to every lane.
	typedef struct packed {
		logic             start;
		op_t              op;
		logic [MUL_W-1:0] mul;
		logic [MUL_W-1:0] dvs;
	} lane_ctrl_t;

	// Request from a lane to its scaling unit.
	typedef struct packed {
		logic             start;
		logic             div_mode;
		logic             narrow;
		sum_t             value;
		logic [MUL_W-1:0] mul;
		logic [MUL_W-1:0] dvs;
	} scale_req_t;

	function automatic samp_vec_t item_samples(item_t it);
		samp_vec_t v;
		v[0] = it.look_x;
		v[1] = it.look_y;
		v[2] = it.look_z;
		v[3] = it.up_x;
		v[4] = it.up_y;
		v[5] = it.up_z;
		return v;
	endfunction

	function automatic result_t merge_result(samp_vec_t v);
		result_t r;
		r.smooth_look_x = v[0];
		r.smooth_look_y = v[1];
		r.smooth_look_z = v[2];
		r.smooth_up_x   = v[3];
		r.smooth_up_y   = v[4];
		r.smooth_up_z   = v[5];
		return r;
	endfunction

endpackage

>>> hdl/variable_damp_vector_smoother_core.sv
// Top level of the six-channel damped vector smoother.
// Depends on vds_pkg, vds_seq and vds_lane.
//
// The block smooths a look vector and an up vector, three axes each, with a
// leaky integrator whose damping factor may change from word to word. Input
// words arrive on item/item_valid/item_stall and carry six Q4.20 samples, a
// Q0.16 damping factor, a tick count and a restart flag. One result word per
// input word leaves on result/result_valid/result_stall. Six lanes, one per
// channel, hold the 48-bit sums and run in lockstep; a sequencer steps them
// through the work of each word, and the merging stage packs the lane outputs.
//
// A damping change and a restart each add a step to the work of a word; each
// of those two steps is a 64-bit division that retires four quotient bits per
// cycle, and each tick passes through the lane's shared 24x17 multiplier. One
// word is worked on at a time, so a word is not accepted until the result of
// the last one is written to the output register; the next word is taken in
// the cycle after that result is written, even while it is still stalled.
// Reset clears all sums to zero and sets the stored damping to 0.99. A
// stalled result holds; the next word's result waits until the register frees.
module variable_damp_vector_smoother_core import vds_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	item_t             item_q;
	logic              item_fire;
	samp_vec_t         samples;
	lane_ctrl_t        lane_ctrl;
	logic [CHANNELS-1:0] lane_done;
	samp_vec_t         lane_smooth;
	logic              all_done;
	logic              out_free;
	logic              emit;
	logic              result_valid_q;
	result_t           result_q;

	assign item_fire = item_valid && !item_stall;

	// The word stays here for the whole computation.
	always_ff @(posedge clk) begin
		if (item_fire) begin
			item_q <= item;
		end
	end

	assign samples = item_samples(item_q);

	vds_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_fire  (item_fire),
		.damping    (item_q.damping),
		.ticks      (item_q.ticks),
		.restart    (item_q.restart),
		.all_done   (all_done),
		.out_free   (out_free),
		.item_stall (item_stall),
		.emit       (emit),
		.ctrl       (lane_ctrl)
	);

	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		vds_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lane_ctrl),
			.sample (samples[g]),
			.done   (lane_done[g]),
			.smooth (lane_smooth[g])
		);
	end

	// All lanes run the same schedule; the step is over when every lane reports.
	assign all_done = &lane_done;

	// The output register frees when empty or when its word is taken this cycle.
	assign out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= merge_result(lane_smooth);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> hdl/vds_scale.sv
// Multi-cycle scaling unit: round(|v|*m/d) or round(|v|*m/65536), saturated, sign restored.
// Depends on vds_pkg; one instance per lane.
module vds_scale import vds_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  scale_req_t req,
	output logic       done,
	output sum_t       res
);

	scale_state_t state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic              neg_q, div_q, narrow_q;
	logic [SUM_W-1:0]  mag_q;
	logic [MUL_W-1:0]  mul_q, dvs_q;
	logic [PROD_W-1:0] pp_q;
	logic [ACC_W-1:0]  acc_q;
	logic [DAMP_W-1:0] rem_q;
	sum_t              res_q;

	logic [SUM_W-1:0]  mag_d;
	logic [HALF_W-1:0] pp_mux;
	logic [PROD_W-1:0] pp_d;
	logic [DAMP_W-1:0] rnd;
	logic [ACC_W-1:0]  div_acc;
	logic [DAMP_W-1:0] div_rem;
	logic [MUL_W-1:0]  trial;
	logic [ACC_W-1:0]  quot, cap, clipped;
	logic [SUM_W-1:0]  res_d;

	assign mag_d  = req.value[SUM_W-1] ? SUM_W'(-req.value) : SUM_W'(req.value);
	assign pp_mux = (state_q == SC_MUL_LO) ? mag_q[HALF_W-1:0] : mag_q[SUM_W-1:HALF_W];
	assign pp_d   = PROD_W'(pp_mux) * PROD_W'(mul_q);
	assign rnd    = div_q ? dvs_q[MUL_W-1:1] : HALF_LSB_Q16;

	// Restoring division, several quotient bits per cycle. The quotient bits
	// shift into the bottom of the dividend register as it empties.
	always_comb begin
		div_acc = acc_q;
		div_rem = rem_q;
		trial   = '0;
		for (int k = 0; k < DIV_BITS; k++) begin
			trial   = {div_rem, div_acc[ACC_W-1]};
			div_acc = {div_acc[ACC_W-2:0], 1'b0};
			if (trial >= dvs_q) begin
				trial      = trial - dvs_q;
				div_acc[0] = 1'b1;
			end
			div_rem = trial[DAMP_W-1:0];
		end
	end

	// Negative results may reach one step further than positive ones.
	always_comb begin
		quot    = div_q ? acc_q : (acc_q >> DAMP_W);
		cap     = (ACC_W'(1) << ((narrow_q ? SAMP_W : SUM_W) - 1)) - ACC_W'(!neg_q);
		clipped = (quot > cap) ? cap : quot;
		res_d   = neg_q ? (SUM_W'(0) - clipped[SUM_W-1:0]) : clipped[SUM_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SC_IDLE: begin
				if (req.start) begin
					state_d = SC_MUL_LO;
				end
			end
			SC_MUL_LO: state_d = SC_MUL_HI;
			SC_MUL_HI: state_d = SC_ACC;
			SC_ACC:    state_d = div_q ? SC_DIV : SC_FIN;
			SC_DIV: begin
				if (cnt_q == CNT_W'(DIV_CYCLES - 1)) begin
					state_d = SC_FIN;
				end
			end
			SC_FIN:    state_d = SC_IDLE;
			default:   state_d = SC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == SC_FIN);
			if (state_q == SC_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			SC_IDLE: begin
				if (req.start) begin
					neg_q    <= req.value[SUM_W-1];
					mag_q    <= mag_d;
					mul_q    <= req.mul;
					dvs_q    <= req.dvs;
					div_q    <= req.div_mode;
					narrow_q <= req.narrow;
				end
			end
			SC_MUL_LO: pp_q <= pp_d;
			SC_MUL_HI: begin
				acc_q <= ACC_W'(pp_q) + ACC_W'(rnd);
				pp_q  <= pp_d;
			end
			SC_ACC: begin
				acc_q <= acc_q + {pp_q[PROD_W-2:0], {HALF_W{1'b0}}};
				rem_q <= '0;
			end
			SC_DIV: begin
				acc_q <= div_acc;
				rem_q <= div_rem;
			end
			SC_FIN:  res_q <= res_d;
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

>>> hdl/vds_lane.sv
// One smoothing lane: the channel sum register and its scaling unit.
// Depends on vds_pkg and vds_scale.
module vds_lane import vds_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lane_ctrl_t ctrl,
	input  samp_t      sample,
	output logic       done,
	output samp_t      smooth
);

	sum_t                   sum_q;
	sum_t                   samp_ext;
	sum_t                   res;
	logic                   scale_done;
	scale_req_t             req;
	logic signed [SUM_W:0]  tick_wide;
	sum_t                   tick_sat;

	assign samp_ext = {{(SUM_W - SAMP_W){sample[SAMP_W-1]}}, sample};

	always_comb begin
		req.start    = ctrl.start;
		req.div_mode = (ctrl.op == OP_RESCALE) || (ctrl.op == OP_PRESET);
		req.narrow   = (ctrl.op == OP_OUTPUT);
		req.value    = (ctrl.op == OP_PRESET) ? samp_ext : sum_q;
		req.mul      = ctrl.mul;
		req.dvs      = ctrl.dvs;
	end

	vds_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.done   (scale_done),
		.res    (res)
	);

	// One integration tick adds the sample to the decayed sum and clips at 48 bits.
	assign tick_wide = {res[SUM_W-1], res} + {samp_ext[SUM_W-1], samp_ext};
	always_comb begin
		if (tick_wide[SUM_W] != tick_wide[SUM_W-1]) begin
			tick_sat = tick_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
			                            : {1'b0, {(SUM_W - 1){1'b1}}};
		end else begin
			tick_sat = tick_wide[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (scale_done) begin
			unique case (ctrl.op)
				OP_RESCALE: sum_q <= res;
				OP_PRESET:  sum_q <= res;
				OP_TICK:    sum_q <= tick_sat;
				OP_OUTPUT:  ;
			endcase
		end
	end

	assign done   = scale_done;
	assign smooth = res[SAMP_W-1:0];

endmodule

>>> hdl/vds_seq.sv
// Item sequencer: walks every lane through rescale, preset, ticks and output in lockstep.
// Depends on vds_pkg.
module vds_seq import vds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_fire,
	input  logic [DAMP_W-1:0] damping,
	input  logic [TICK_W-1:0] ticks,
	input  logic              restart,
	input  logic              all_done,
	input  logic              out_free,
	output logic              item_stall,
	output logic              emit,
	output lane_ctrl_t        ctrl
);

	seq_state_t        state_q, state_d;
	logic              launch_q, launch_d;
	logic [DAMP_W-1:0] cur_damp_q;
	logic [TICK_W-1:0] ticks_left_q;
	logic [TICK_W-1:0] tick_clamp;

	function automatic seq_state_t after_preset(logic [TICK_W-1:0] left);
		return (left != '0) ? SQ_TICK : SQ_OUTPUT;
	endfunction

	assign tick_clamp = (ticks > MAX_TICKS) ? MAX_TICKS : ticks;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SQ_IDLE;
			launch_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= launch_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		launch_d = 1'b0;
		emit     = 1'b0;
		unique case (state_q)
			SQ_IDLE: begin
				if (item_fire) begin
					state_d = SQ_PLAN;
				end
			end
			SQ_PLAN: begin
				launch_d = 1'b1;
				if (damping != cur_damp_q) begin
					state_d = SQ_RESCALE;
				end else if (restart) begin
					state_d = SQ_PRESET;
				end else begin
					state_d = after_preset(tick_clamp);
				end
			end
			SQ_RESCALE: begin
				if (all_done) begin
					launch_d = 1'b1;
					state_d  = restart ? SQ_PRESET : after_preset(ticks_left_q);
				end
			end
			SQ_PRESET: begin
				if (all_done) begin
					launch_d = 1'b1;
					state_d  = after_preset(ticks_left_q);
				end
			end
			SQ_TICK: begin
				if (all_done) begin
					launch_d = 1'b1;
					state_d  = (ticks_left_q == TICK_W'(1)) ? SQ_OUTPUT : SQ_TICK;
				end
			end
			SQ_OUTPUT: begin
				if (all_done) begin
					state_d = SQ_EMIT;
				end
			end
			SQ_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = SQ_IDLE;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_damp_q   <= DAMP_RESET;
			ticks_left_q <= '0;
		end else begin
			if (state_q == SQ_PLAN) begin
				ticks_left_q <= tick_clamp;
			end else if ((state_q == SQ_TICK) && all_done) begin
				ticks_left_q <= ticks_left_q - TICK_W'(1);
			end
			if ((state_q == SQ_RESCALE) && all_done) begin
				cur_damp_q <= damping;
			end
		end
	end

	always_comb begin
		ctrl.start = launch_q;
		ctrl.dvs   = ONE_Q16 - MUL_W'(damping);
		unique case (state_q)
			SQ_RESCALE: begin
				ctrl.op  = OP_RESCALE;
				ctrl.mul = ONE_Q16 - MUL_W'(cur_damp_q);
			end
			SQ_PRESET: begin
				ctrl.op  = OP_PRESET;
				ctrl.mul = ONE_Q16;
			end
			SQ_TICK: begin
				ctrl.op  = OP_TICK;
				ctrl.mul = MUL_W'(damping);
			end
			default: begin
				ctrl.op  = OP_OUTPUT;
				ctrl.mul = ONE_Q16 - MUL_W'(damping);
			end
		endcase
	end

	assign item_stall = (state_q != SQ_IDLE);

endmodule

>>> hdl/vds_checker.sv
// Port-level checks for the damped vector smoother, bound to the top level.
// Depends on vds_pkg and variable_damp_vector_smoother_core.
module vds_checker import vds_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// A stalled result word stays put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed");

	// One word is worked on at a time: acceptance closes the input.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input open in the cycle after a word was accepted");

	// A new result only appears at the end of a busy period.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared without a word in progress");

	// Writing the result ends the word, so the input opens at once.
	a_open_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !item_stall)
		else $error("input still closed when the result was written");

endmodule

bind variable_damp_vector_smoother_core vds_checker u_vds_checker (.*);

>>> test/testbench.sv
// Self-checking testbench for variable_damp_vector_smoother_core.
// Depends on vds_pkg for the word types and on the core itself; it carries its
// own bit-exact model of the damped six-channel integrator.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import vds_pkg::*;

	// The end-of-run wait covers the worst latency: a damping change, a restart and 15 ticks.
	localparam int    DRAIN_CYCLES = 160;
	localparam int    RANDOM_WORDS = 1200;
	localparam samp_t SAMP_MAX     = 24'sh7FFFFF;
	localparam samp_t SAMP_MIN     = 24'sh800000;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	variable_damp_vector_smoother_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #10 clk = ~clk;

	// The model's copy of the block state: six Q28.20 sums and the damping
	// factor they currently belong to.
	longint            chan_sum [CHANNELS];
	logic [DAMP_W-1:0] held_damp;

	// Result words predicted but not yet seen at the output, oldest first.
	result_t expected_results [$];

	// Traffic shaping. The sender and the receiver each draw a random wait
	// per word while their idle flag is set; rx_hold_left is a one-off long
	// hold-off that the receiver process counts down cycle by cycle.
	bit tx_idle      = 1'b1;
	bit rx_idle      = 1'b1;
	int rx_hold_left = 0;

	int words_sent      = 0;
	int results_checked = 0;
	int damp_changes    = 0;
	int restarts        = 0;
	int mismatches      = 0;

	// A result_t cast to samp_vec_t puts smooth_up_z at index 0, so the names
	// run from the last field to the first.
	string field_name [CHANNELS] = '{"smooth_up_z", "smooth_up_y", "smooth_up_x",
		"smooth_look_z", "smooth_look_y", "smooth_look_x"};

	// round(v*m/d) with halves away from zero, clipped to a w-bit signed range.
	// The magnitude is at most 2^47 and m at most 2^16, so the product fits in
	// 64 unsigned bits.
	function automatic longint round_scaled(longint v, longint unsigned m,
			longint unsigned d, int w);
		bit                neg;
		longint unsigned   mag;
		longint unsigned   cap;
		longint unsigned   q;
		neg = (v < 0);
		mag = neg ? -v : v;
		cap = (64'd1 << (w - 1)) - 64'd1 + (neg ? 64'd1 : 64'd0);
		q   = (mag * m + d / 2) / d;
		if (q > cap)
			q = cap;
		return neg ? -$signed(q) : $signed(q);
	endfunction

	function automatic longint clip(longint v, int w);
		longint hi;
		hi = (64'sd1 <<< (w - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	// Advances the model by one input word and returns the result it gives.
	// Order matters: rescale to the new damping first, then the preset, then
	// the ticks, and the output scaling last.
	function automatic result_t smooth_word(item_t w);
		samp_vec_t         s;
		samp_vec_t         o;
		logic [DAMP_W-1:0] d;
		int                n;
		longint            p;
		result_t           r;
		s[0] = w.look_x;
		s[1] = w.look_y;
		s[2] = w.look_z;
		s[3] = w.up_x;
		s[4] = w.up_y;
		s[5] = w.up_z;
		d = w.damping;
		n = (w.ticks > MAX_TICKS) ? MAX_TICKS : w.ticks;
		if (d != held_damp) begin
			for (int c = 0; c < CHANNELS; c++)
				chan_sum[c] = round_scaled(chan_sum[c], 65536 - held_damp, 65536 - d, SUM_W);
			held_damp = d;
			damp_changes++;
		end
		if (w.restart) begin
			for (int c = 0; c < CHANNELS; c++)
				chan_sum[c] = round_scaled(longint'(s[c]), 65536, 65536 - d, SUM_W);
			restarts++;
		end
		for (int t = 0; t < n; t++) begin
			for (int c = 0; c < CHANNELS; c++) begin
				p = round_scaled(chan_sum[c], d, 65536, SUM_W);
				chan_sum[c] = clip(p + longint'(s[c]), SUM_W);
			end
		end
		for (int c = 0; c < CHANNELS; c++)
			o[c] = samp_t'(round_scaled(chan_sum[c], 65536 - d, 65536, SAMP_W));
		r.smooth_look_x = o[0];
		r.smooth_look_y = o[1];
		r.smooth_look_z = o[2];
		r.smooth_up_x   = o[3];
		r.smooth_up_y   = o[4];
		r.smooth_up_z   = o[5];
		return r;
	endfunction

	function automatic item_t pack_word(samp_vec_t s, logic [DAMP_W-1:0] d,
			logic [TICK_W-1:0] t, logic r);
		item_t w;
		w.look_x  = s[0];
		w.look_y  = s[1];
		w.look_z  = s[2];
		w.up_x    = s[3];
		w.up_y    = s[4];
		w.up_z    = s[5];
		w.damping = d;
		w.ticks   = t;
		w.restart = r;
		return w;
	endfunction

	// Damping values lean toward the useful top of the range and the two ends.
	function automatic logic [DAMP_W-1:0] pick_damping();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return DAMP_RESET;
			3: return DAMP_W'($urandom_range(60000, 65535));
			4: return DAMP_W'($urandom_range(65400, 65535));
			default: return DAMP_W'($urandom);
		endcase
	endfunction

	// Mostly a slow wander around a center value, sometimes a wild sample or
	// one of the range ends.
	function automatic samp_t random_sample(samp_t center);
		case ($urandom_range(0, 9))
			0, 1: return samp_t'($urandom);
			2: return SAMP_MAX;
			3: return SAMP_MIN;
			default: return center + samp_t'(int'($urandom_range(0, 4095)) - 2048);
		endcase
	endfunction

	function automatic item_t random_word(logic [DAMP_W-1:0] d, samp_vec_t center);
		samp_vec_t s;
		for (int c = 0; c < CHANNELS; c++)
			s[c] = random_sample(center[c]);
		return pack_word(s, d,
			($urandom_range(0, 3) == 0) ? TICK_W'($urandom_range(0, 15))
				: TICK_W'($urandom_range(0, 3)),
			$urandom_range(0, 9) == 0);
	endfunction

	// Offers one word and returns once the core has taken it. Valid is lowered
	// only when a gap is drawn, so back-to-back words keep it high throughout.
	task automatic send_word(item_t w);
		int gap;
		gap = tx_idle ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall !== 1'b0)
			@(posedge clk);
		words_sent++;
		expected_results.push_back(smooth_word(w));
	endtask

	// Stops offering words and waits until every expected result is back,
	// then a while longer so that a stray extra result would still show up.
	task automatic settle();
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_result(result_t got);
		result_t   want;
		samp_vec_t gv;
		samp_vec_t wv;
		if (expected_results.size() == 0) begin
			mismatches++;
			$display("%0t: result word with nothing expected: %h", $time, got);
			return;
		end
		want = expected_results.pop_front();
		results_checked++;
		gv = got;
		wv = want;
		for (int c = 0; c < CHANNELS; c++) begin
			if (gv[c] !== wv[c]) begin
				mismatches++;
				$display("%0t: %s expected %0d (%h) got %0d (%h)", $time, field_name[c],
					wv[c], wv[c], gv[c], gv[c]);
			end
		end
	endtask

	// Output side. Every value is sampled at the rising edge before any update
	// of that edge lands, so a word counts as taken exactly when valid was high
	// and stall low going into the edge. After each taken word a fresh wait is
	// drawn; it only runs down while a result is actually on offer, so the
	// stall always lands on a real word.
	initial begin : result_sink
		int wait_left;
		wait_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid === 1'b1 && result_stall == 1'b0) begin
				check_result(result);
				wait_left = rx_idle ? $urandom_range(0, 19) : 0;
			end else if (result_valid === 1'b1 && wait_left > 0) begin
				wait_left--;
			end
			if (rx_hold_left > 0)
				rx_hold_left--;
			result_stall <= (rx_hold_left > 0) || (wait_left > 0);
		end
	end

	// Right after reset the sums are zero, so any word without a restart and
	// without ticks must read back as zero on all six channels.
	task automatic test_reset_state();
		send_word(pack_word({CHANNELS{SAMP_MAX}}, DAMP_RESET, 4'd0, 1'b0));
		settle();
	endtask

	// Largest and smallest samples, alternating signs and toggling bit
	// patterns, so that every sample bit is seen at both values.
	task automatic test_sample_extremes();
		send_word(pack_word({CHANNELS{SAMP_MAX}}, DAMP_RESET, 4'd0, 1'b1));
		send_word(pack_word({CHANNELS{SAMP_MIN}}, DAMP_RESET, 4'd15, 1'b0));
		send_word(pack_word({SAMP_MAX, SAMP_MIN, SAMP_MAX, SAMP_MIN, SAMP_MAX, SAMP_MIN},
			DAMP_RESET, 4'd1, 1'b1));
		send_word(pack_word({24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 24'sh555555,
			24'shAAAAAA, 24'sh555555}, DAMP_RESET, 4'd2, 1'b0));
		settle();
	endtask

	// Zero damping turns each tick into a plain pass-through of the sample.
	task automatic test_damping_zero();
		send_word(pack_word({CHANNELS{24'sh123456}}, 16'd0, 4'd1, 1'b0));
		send_word(pack_word({CHANNELS{SAMP_MIN}}, 16'd0, 4'd0, 1'b0));
		send_word(pack_word({24'sh000001, 24'shFFFFFF, 24'sh400000, 24'shC00000,
			SAMP_MAX, SAMP_MIN}, 16'd0, 4'd3, 1'b1));
		settle();
	endtask

	// The heaviest damping makes the sums run up to 2^16 times the sample,
	// which is where the sums come closest to their 48-bit limits; jumping
	// between the two damping ends rescales them by the full factor.
	task automatic test_sum_limits();
		send_word(pack_word({CHANNELS{SAMP_MAX}}, 16'hFFFF, 4'd15, 1'b1));
		send_word(pack_word({CHANNELS{SAMP_MAX}}, 16'd0, 4'd0, 1'b0));
		send_word(pack_word({CHANNELS{SAMP_MAX}}, 16'hFFFF, 4'd15, 1'b0));
		send_word(pack_word({CHANNELS{SAMP_MIN}}, 16'hFFFF, 4'd15, 1'b1));
		send_word(pack_word({CHANNELS{SAMP_MIN}}, 16'd1, 4'd15, 1'b0));
		settle();
	endtask

	// A damping change together with a restart: the rescale happens first and
	// the preset at the new damping then overwrites it.
	task automatic test_change_with_restart();
		send_word(pack_word({CHANNELS{24'sh0ABCDE}}, DAMP_RESET, 4'd4, 1'b1));
		send_word(pack_word({CHANNELS{24'shF54321}}, 16'd32768, 4'd2, 1'b1));
		send_word(pack_word({24'sh7FFFFF, 24'sh000000, 24'sh800000, 24'sh100000,
			24'shF00000, 24'sh000001}, 16'hFFFF, 4'd0, 1'b1));
		settle();
	endtask

	// No ticks: the sums only move through a rescale or a preset, yet a
	// result word still comes out.
	task automatic test_zero_ticks();
		send_word(pack_word({CHANNELS{24'sh222222}}, 16'hFFFF, 4'd0, 1'b0));
		send_word(pack_word({CHANNELS{24'shDDDDDD}}, 16'd50000, 4'd0, 1'b0));
		send_word(pack_word({CHANNELS{24'sh000000}}, 16'd50000, 4'd0, 1'b1));
		settle();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering
	// words back to back; the core finishes one word, parks its result, works
	// the next one and then has to stall its input.
	task automatic test_output_backpressure();
		samp_vec_t center;
		for (int c = 0; c < CHANNELS; c++)
			center[c] = samp_t'($urandom);
		tx_idle      = 1'b0;
		rx_hold_left = 400;
		repeat (10) send_word(random_word(16'd60000, center));
		tx_idle = 1'b1;
		settle();
	endtask

	// Long runs at one damping factor with slowly moving samples, as the
	// block sees them in use, broken up by damping changes, restarts and now
	// and then a word of pure noise. Idling on either side switches on and
	// off in stretches.
	task automatic test_random_traffic(int count);
		logic [DAMP_W-1:0] d;
		samp_vec_t         center;
		item_t             w;
		d = pick_damping();
		for (int c = 0; c < CHANNELS; c++)
			center[c] = samp_t'($urandom);
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				tx_idle = ($urandom_range(0, 3) != 0);
				rx_idle = ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 15) == 0) begin
				for (int c = 0; c < CHANNELS; c++)
					center[c] = samp_t'($urandom);
			end
			w = random_word(d, center);
			if ($urandom_range(0, 11) == 0) begin
				d         = pick_damping();
				w.damping = d;
				w.restart = 1'($urandom_range(0, 1));
			end
			if ($urandom_range(0, 39) == 0)
				w = pack_word({samp_t'($urandom), samp_t'($urandom), samp_t'($urandom),
					samp_t'($urandom), samp_t'($urandom), samp_t'($urandom)},
					DAMP_W'($urandom), TICK_W'($urandom), 1'($urandom));
			send_word(w);
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		settle();
	endtask

	initial begin : run_all
		for (int c = 0; c < CHANNELS; c++)
			chan_sum[c] = 0;
		held_damp = DAMP_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_sample_extremes();
		test_damping_zero();
		test_sum_limits();
		test_change_with_restart();
		test_zero_ticks();
		test_output_backpressure();
		test_random_traffic(RANDOM_WORDS);

		$display("Sent %0d words and checked %0d results, %0d mismatching fields.",
			words_sent, results_checked, mismatches);
		$display("Traffic held %0d damping changes and %0d restarts under gaps and stalls.",
			damp_changes, restarts);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog: well beyond the slowest legal run of all the words above.
	initial begin : watchdog
		#20_000_000;
		$display("Timed out with %0d results still expected.", expected_results.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
